// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; they compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/csrspmv_pkg.sv -----
// ---------------------------------------------------------------------------
// CSR SpMV package
// Shared widths, item mode codes and the front-to-back operation record.
// ---------------------------------------------------------------------------
package csrspmv_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned ValW    = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned RowNumW = 16;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QLvlW   = $clog2(QDepth + 1);

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_NONZERO = 2'd1,
    MODE_EMPTY   = 2'd2,
    MODE_UNUSED  = 2'd3
  } csrspmv_mode_e;

  // One queued operation: a product to accumulate, optionally closing the row.
  typedef struct packed {
    logic signed [AccW-1:0] prod;
    logic                   close;
    logic signed [ValW-1:0] rhs;
  } csrspmv_op_t;

endpackage

// ----- sv/csrspmv_in_if.sv -----
// ---------------------------------------------------------------------------
// CSR SpMV input channel
// Valid/ready channel carrying one stream item per beat.
// ---------------------------------------------------------------------------
interface csrspmv_in_if
  import csrspmv_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [ModeW-1:0]       mode;
  logic [IdxW-1:0]        index;
  logic signed [ValW-1:0] value;
  logic                   row_end;
  logic signed [ValW-1:0] rhs;

  modport source (output valid, output mode, output index, output value,
                  output row_end, output rhs, input ready);
  modport sink   (input valid, input mode, input index, input value,
                  input row_end, input rhs, output ready);
endinterface

// ----- sv/csrspmv_out_if.sv -----
// ---------------------------------------------------------------------------
// CSR SpMV result channel
// Valid/ready channel carrying one row result per beat.
// ---------------------------------------------------------------------------
interface csrspmv_out_if
  import csrspmv_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] row_value;
  logic [RowNumW-1:0]     row_number;
  logic                   saturated;

  modport source (output valid, output row_value, output row_number,
                  output saturated, input ready);
  modport sink   (input valid, input row_value, input row_number,
                  input saturated, output ready);
endinterface

// ----- sv/csrspmv_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module csrspmv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/csrspmv_front.sv -----
// ---------------------------------------------------------------------------
// CSR SpMV front end
// Accepts items, keeps the vector store, forms products and queues row work.
// ---------------------------------------------------------------------------
module csrspmv_front
  import csrspmv_pkg::*;
#(
  parameter int unsigned VectorDepth = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  csrspmv_in_if.sink         in_i,
  input  logic [QLvlW-1:0]   q_level_i,
  output logic               push_valid_o,
  output csrspmv_op_t        push_op_o
);

  localparam int unsigned AddrW = $clog2(VectorDepth);

  csrspmv_mode_e          mode;
  logic                   accept;
  logic [31:0]            idx_wide;
  logic                   in_range;
  logic [QLvlW:0]         reserved;

  logic                   f1_v_q, f1_v_d;
  logic                   f1_nz_q;
  logic                   f1_close_q;
  logic                   f1_inr_q;
  logic signed [ValW-1:0] f1_value_q;
  logic signed [ValW-1:0] f1_rhs_q;
  logic [ValW-1:0]        rd_data;
  logic signed [ValW-1:0] opnd;
  logic signed [AccW-1:0] prod;

  assign mode     = csrspmv_mode_e'(in_i.mode);
  assign idx_wide = 32'(in_i.index);
  assign in_range = idx_wide < 32'(VectorDepth);

  // Space is reserved for the item still in the product stage, so a push
  // never finds the queue full.
  assign reserved   = {1'b0, q_level_i} + (QLvlW + 1)'(f1_v_q);
  assign in_i.ready = reserved < (QLvlW + 1)'(QDepth);
  assign accept     = in_i.valid && in_i.ready;

  csrspmv_ram #(
    .Width (ValW),
    .Depth (VectorDepth)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (mode == MODE_LOAD) && in_range),
    .waddr_i (idx_wide[AddrW-1:0]),
    .wdata_i (in_i.value),
    .re_i    (accept && (mode == MODE_NONZERO)),
    .raddr_i (idx_wide[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  assign f1_v_d = accept && ((mode == MODE_NONZERO) || (mode == MODE_EMPTY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= f1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_v_d) begin
      f1_nz_q    <= (mode == MODE_NONZERO);
      f1_close_q <= (mode == MODE_EMPTY) || in_i.row_end;
      f1_inr_q   <= in_range;
      f1_value_q <= in_i.value;
      f1_rhs_q   <= in_i.rhs;
    end
  end

  assign opnd = f1_inr_q ? $signed(rd_data) : '0;
  assign prod = f1_value_q * opnd;

  always_comb begin
    push_valid_o    = f1_v_q;
    push_op_o.prod  = f1_nz_q ? prod : '0;
    push_op_o.close = f1_close_q;
    push_op_o.rhs   = f1_rhs_q;
  end

endmodule

// ----- sv/csrspmv_queue.sv -----
// ---------------------------------------------------------------------------
// CSR SpMV operation queue
// Short FIFO that decouples the product front end from the accumulator.
// ---------------------------------------------------------------------------
module csrspmv_queue
  import csrspmv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csrspmv_op_t      push_op_i,
  input  logic             pop_i,
  output logic             head_valid_o,
  output csrspmv_op_t      head_op_o,
  output logic [QLvlW-1:0] level_o
);

  csrspmv_op_t      entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QLvlW-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    level_d  = level_q + QLvlW'(push_i) - QLvlW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign head_valid_o = (level_q != '0);
  assign head_op_o    = entry_q[rd_ptr_q];
  assign level_o      = level_q;

endmodule

// ----- sv/csrspmv_back.sv -----
// ---------------------------------------------------------------------------
// CSR SpMV back end
// Accumulates products per row and turns closed rows into rounded results.
// ---------------------------------------------------------------------------
module csrspmv_back
  import csrspmv_pkg::*;
#(
  parameter int unsigned RowCountBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sub_en_i,
  input  logic        q_valid_i,
  input  csrspmv_op_t q_op_i,
  output logic        q_pop_o,
  csrspmv_out_if.source res_o
);

  localparam int unsigned DiffW = AccW + 2;
  localparam int unsigned ShW   = DiffW - 16;

  // Accumulate stage.
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [RowCountBits-1:0] row_cnt_q, row_cnt_d;
  logic signed [AccW:0]    sum_wide;
  logic signed [AccW-1:0]  sum_sat;

  // Close stage: finished row accumulator.
  logic                    b2_v_q, b2_v_d;
  logic signed [AccW-1:0]  b2_acc_q;
  logic signed [ValW-1:0]  b2_rhs_q;
  logic [RowNumW-1:0]      b2_row_q;
  logic                    b2_free, b2_move;

  // Difference stage.
  logic                    b3_v_q, b3_v_d;
  logic signed [DiffW-1:0] b3_diff_q, diff;
  logic [RowNumW-1:0]      b3_row_q;
  logic                    b3_free, b3_move;

  // Output register.
  logic                    out_v_q, out_v_d;
  logic signed [ValW-1:0]  out_value_q;
  logic [RowNumW-1:0]      out_row_q;
  logic                    out_sat_q;
  logic                    out_free;

  logic signed [ShW-1:0]   shifted;
  logic signed [ShW:0]     rounded;
  logic signed [ValW-1:0]  clamped;
  logic                    clip;

  assign out_free = !out_v_q || res_o.ready;
  assign b3_move  = b3_v_q && out_free;
  assign b3_free  = !b3_v_q || out_free;
  assign b2_move  = b2_v_q && b3_free;
  assign b2_free  = !b2_v_q || b3_free;
  assign q_pop_o  = q_valid_i && (!q_op_i.close || b2_free);

  // Saturating 64-bit add of the incoming product.
  always_comb begin
    sum_wide = {acc_q[AccW-1], acc_q} + {q_op_i.prod[AccW-1], q_op_i.prod};
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      sum_sat = sum_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[AccW-1:0];
    end
  end

  always_comb begin
    acc_d     = acc_q;
    row_cnt_d = row_cnt_q;
    if (q_pop_o) begin
      if (q_op_i.close) begin
        acc_d     = '0;
        row_cnt_d = row_cnt_q + RowCountBits'(1);
      end else begin
        acc_d = sum_sat;
      end
    end
  end

  assign b2_v_d = (q_pop_o && q_op_i.close) || (b2_v_q && !b2_move);
  assign b3_v_d = b2_move || (b3_v_q && !b3_move);
  assign out_v_d = b3_move || (out_v_q && !res_o.ready);

  // The difference is formed at full width, so results far outside the
  // 64-bit range still saturate toward the right sign.
  always_comb begin
    if (sub_en_i) begin
      diff = {{(DiffW-ValW-16){b2_rhs_q[ValW-1]}}, b2_rhs_q, 16'b0}
           - {{(DiffW-AccW){b2_acc_q[AccW-1]}}, b2_acc_q};
    end else begin
      diff = {{(DiffW-AccW){b2_acc_q[AccW-1]}}, b2_acc_q};
    end
  end

  // Round half toward plus infinity, then clamp to Q16.16.
  always_comb begin
    shifted = b3_diff_q[DiffW-1:16];
    rounded = {shifted[ShW-1], shifted} + (ShW + 1)'(b3_diff_q[15]);
    clip    = 1'b0;
    if (rounded > (ShW + 1)'(signed'({1'b0, {(ValW-1){1'b1}}}))) begin
      clamped = {1'b0, {(ValW-1){1'b1}}};
      clip    = 1'b1;
    end else if (rounded < -(ShW + 1)'(signed'({1'b0, 1'b1, {(ValW-1){1'b0}}}))) begin
      clamped = {1'b1, {(ValW-1){1'b0}}};
      clip    = 1'b1;
    end else begin
      clamped = rounded[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      row_cnt_q <= '0;
      b2_v_q    <= 1'b0;
      b3_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      row_cnt_q <= row_cnt_d;
      b2_v_q    <= b2_v_d;
      b3_v_q    <= b3_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.close) begin
      b2_acc_q <= sum_sat;
      b2_rhs_q <= q_op_i.rhs;
      b2_row_q <= RowNumW'(row_cnt_q);
    end
    if (b2_move) begin
      b3_diff_q <= diff;
      b3_row_q  <= b2_row_q;
    end
    if (b3_move) begin
      out_value_q <= clamped;
      out_row_q   <= b3_row_q;
      out_sat_q   <= clip;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.row_value  = out_value_q;
  assign res_o.row_number = out_row_q;
  assign res_o.saturated  = out_sat_q;

endmodule

// ----- sv/csr_spmv_residual_unit.sv -----
// A closing beat passes the product stage, queue, close and difference stages and
// output register. Throughput: one item per cycle unless a full queue stalls ready;
// the multiply-accumulate loop closes in the accumulate stage, and the queue refills no slower than it drains.
// Reset: subtract_enable returns to 1, accumulator and row number clear to
// zero; vector store contents are undefined until loaded.
// ---------------------------------------------------------------------------
// CSR SpMV residual unit
// Row-by-row sparse matrix-vector product with optional rhs residual output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csr_spmv_residual_unit
  import csrspmv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH   = 1024,
  parameter int unsigned ROW_COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  csrspmv_in_if.sink     in_i,
  csrspmv_out_if.source  res_o
);

  logic             sub_en_q;
  logic             q_push;
  csrspmv_op_t      q_push_op;
  logic             q_pop;
  logic             q_head_valid;
  csrspmv_op_t      q_head_op;
  logic [QLvlW-1:0] q_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      sub_en_q <= cfg_wdata_i;
    end
  end

  csrspmv_front #(
    .VectorDepth (VECTOR_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .q_level_i    (q_level),
    .push_valid_o (q_push),
    .push_op_o    (q_push_op)
  );

  csrspmv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_op_i    (q_push_op),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_op_o    (q_head_op),
    .level_o      (q_level)
  );

  csrspmv_back #(
    .RowCountBits (ROW_COUNT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sub_en_i  (sub_en_q),
    .q_valid_i (q_head_valid),
    .q_op_i    (q_head_op),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

  `ASSERT_IMPL(a_queue_no_overflow, clk_i, rst_ni, q_push && !q_pop, q_level < QLvlW'(QDepth))
  `ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, q_pop, q_level != '0)
  `ASSERT_NEXT(a_nonzero_queued, clk_i, rst_ni, in_i.valid && in_i.ready && (in_i.mode == MODE_NONZERO), q_push)

endmodule

// ----- tb/sv/tb_csr_spmv_residual_unit.sv -----
// ---------------------------------------------------------------------------
// CSR SpMV residual unit testbench
// Streams vector loads, matrix nonzeros and empty rows into the unit with
// random gaps and back-pressure, predicts each row result in a local model
// of the unit and checks every result beat against it, field by field.
// ---------------------------------------------------------------------------
module tb_csr_spmv_residual_unit;
  import csrspmv_pkg::*;

  localparam int unsigned VecDepth  = 1024;
  localparam int unsigned RowBits   = 16;
  localparam int          LongHold  = 300;

  localparam logic signed [63:0] Acc64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Acc64Min = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] QMax     = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] QMin     = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    csrspmv_mode_e          mode;
    logic [IdxW-1:0]        index;
    logic signed [ValW-1:0] value;
    logic                   row_end;
    logic signed [ValW-1:0] rhs;
  } stream_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] row_value;
    logic [RowNumW-1:0]     row_number;
    logic                   saturated;
  } row_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  csrspmv_in_if  in_bus ();
  csrspmv_out_if res_bus ();

  csr_spmv_residual_unit #(
    .VECTOR_DEPTH  (VecDepth),
    .ROW_COUNT_BITS(RowBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .res_o      (res_bus)
  );

  // Local copy of the unit's state and its one register.
  logic signed [ValW-1:0] shadow_vec [VecDepth];
  logic signed [AccW-1:0] shadow_acc;
  logic [RowBits-1:0]     shadow_row;
  logic                   shadow_sub;

  stream_item_t stream_items [$];
  row_result_t  expected_rows [$];

  // Generator-side record of which vector entries hold data.
  bit loaded_flag [VecDepth];
  int loaded_list [$];

  int items_queued;
  int items_taken;
  int errors;
  int hold_asked;
  int hold_served;

  stream_item_t cur_item;
  int           send_gap;
  bit           send_burst;
  int           recv_gap;
  int           recv_long;
  bit           recv_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Works out the row result, if any, that one accepted beat causes.
  function automatic void predict_spmv_item(input stream_item_t it);
    logic signed [63:0] elem;
    logic signed [63:0] val64;
    logic signed [63:0] prod;
    logic [64:0]        sum;
    logic [65:0]        diff;
    logic signed [63:0] r;
    logic signed [63:0] q;
    row_result_t        res;
    bit                 forced;
    forced = 1'b0;
    res.saturated = 1'b0;
    case (it.mode)
      MODE_LOAD: begin
        shadow_vec[it.index] = it.value;
        return;
      end
      MODE_UNUSED: return;
      MODE_NONZERO: begin
        elem  = 64'(shadow_vec[it.index]);
        val64 = 64'(it.value);
        prod  = val64 * elem;
        sum   = {shadow_acc[63], shadow_acc} + {prod[63], prod};
        if (sum[64] != sum[63]) shadow_acc = sum[64] ? Acc64Min : Acc64Max;
        else shadow_acc = sum[63:0];
        if (!it.row_end) return;
      end
      default: ;
    endcase

    if (shadow_sub) begin
      diff = {{18{it.rhs[31]}}, it.rhs, 16'h0000} - {{2{shadow_acc[63]}}, shadow_acc};
      if (diff[65:63] != 3'b000 && diff[65:63] != 3'b111) begin
        // The true difference lies far outside Q16.16; clip toward its sign.
        forced = 1'b1;
        q = diff[65] ? QMin : QMax;
        res.saturated = 1'b1;
      end else begin
        r = diff[63:0];
      end
    end else begin
      r = shadow_acc;
    end

    if (!forced) begin
      q = r >>> 16;
      if (r[15]) q = q + 64'sd1;
      if (q > QMax) begin
        q = QMax;
        res.saturated = 1'b1;
      end else if (q < QMin) begin
        q = QMin;
        res.saturated = 1'b1;
      end
    end

    res.row_value  = q[31:0];
    res.row_number = shadow_row;
    expected_rows.insert(expected_rows.size(), res);
    shadow_acc = '0;
    shadow_row = shadow_row + 1'b1;
  endfunction

  // Input driver: offers queued beats with a random gap after each one.
  always @(posedge clk_i or negedge rst_ni) begin : stream_driver
    logic offer;
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.mode    <= MODE_LOAD;
      in_bus.index   <= '0;
      in_bus.value   <= '0;
      in_bus.row_end <= 1'b0;
      in_bus.rhs     <= '0;
      send_gap       = 0;
      send_burst     = 1'b0;
    end else begin
      offer = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        predict_spmv_item(cur_item);
        items_taken++;
        offer = 1'b0;
        if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 6);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stream_items.size() != 0) begin
          cur_item       = stream_items.pop_front();
          in_bus.mode    <= cur_item.mode;
          in_bus.index   <= cur_item.index;
          in_bus.value   <= cur_item.value;
          in_bus.row_end <= cur_item.row_end;
          in_bus.rhs     <= cur_item.rhs;
          offer = 1'b1;
        end
      end
      in_bus.valid <= offer;
    end
  end

  // Result monitor: checks each beat and stalls ready at random.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    row_result_t want;
    row_result_t got;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      recv_gap      = 0;
      recv_long     = 0;
      recv_burst    = 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got.row_value  = res_bus.row_value;
        got.row_number = res_bus.row_number;
        got.saturated  = res_bus.saturated;
        if (expected_rows.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: value=%h row=%0d sat=%0b",
                   $time, got.row_value, got.row_number, got.saturated);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b",
                     $time, want.row_value, want.row_number, want.saturated,
                     got.row_value, got.row_number, got.saturated);
          end
        end
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 6);
      end
      if (hold_served != hold_asked) begin
        hold_served++;
        recv_long = LongHold;
      end
      if (recv_long > 0) begin
        recv_long--;
        res_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input csrspmv_mode_e m, input logic [IdxW-1:0] idx,
                           input logic [ValW-1:0] v, input logic re,
                           input logic [ValW-1:0] rhs);
    stream_item_t it;
    it.mode    = m;
    it.index   = idx;
    it.value   = v;
    it.row_end = re;
    it.rhs     = rhs;
    if (m == MODE_LOAD && !loaded_flag[idx]) begin
      loaded_flag[idx] = 1'b1;
      loaded_list.insert(loaded_list.size(), int'(idx));
    end
    stream_items.insert(stream_items.size(), it);
    items_queued++;
  endtask

  // Q16.16 value drawn from a mix of extremes, small, medium and full range.
  function automatic logic [ValW-1:0] rand_q();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2, 3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      5, 6: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IdxW-1:0] pick_loaded();
    return IdxW'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  // Waits until every beat is taken and every result has arrived.
  task automatic drain();
    while (items_taken != items_queued || expected_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_subtract(input logic en);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_sub = en;
  endtask

  task automatic random_phase(input int n_items);
    int made;
    int kind;
    int len;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(0, 19);
      if (loaded_list.size() == 0 || kind < 3) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          push_item(MODE_LOAD, IdxW'($urandom_range(0, VecDepth - 1)), rand_q(),
                    1'($urandom_range(0, 1)), $urandom());
          made++;
        end
      end else if (kind < 16) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          push_item(MODE_NONZERO, pick_loaded(), rand_q(), i == len - 1, rand_q());
          made++;
        end
      end else if (kind == 16) begin
        push_item(MODE_EMPTY, IdxW'($urandom()), $urandom(), 1'($urandom_range(0, 1)),
                  rand_q());
        made++;
      end else if (kind == 17) begin
        // Unused mode: the unit drops it, so it does not count.
        push_item(MODE_UNUSED, IdxW'($urandom()), $urandom(), 1'($urandom_range(0, 1)),
                  $urandom());
      end else if (kind == 18) begin
        // A row whose nonzeros are closed by an empty-row beat.
        len = $urandom_range(1, 4);
        repeat (len) begin
          push_item(MODE_NONZERO, pick_loaded(), rand_q(), 1'b0, $urandom());
          made++;
        end
        push_item(MODE_EMPTY, IdxW'($urandom()), $urandom(), 1'($urandom_range(0, 1)),
                  rand_q());
        made++;
      end else begin
        // Nonzeros left open; they carry over into the next row.
        len = $urandom_range(1, 3);
        repeat (len) begin
          push_item(MODE_NONZERO, pick_loaded(), rand_q(), 1'b0, $urandom());
          made++;
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    shadow_acc    = '0;
    shadow_row    = '0;
    shadow_sub    = 1'b1;
    items_queued  = 0;
    items_taken   = 0;
    errors        = 0;
    hold_asked    = 0;
    hold_served   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part with subtraction on, as after reset.
    push_item(MODE_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b0, 32'h0);
    push_item(MODE_LOAD, 10'd1023, 32'h8000_0000, 1'b1, 32'h0);
    push_item(MODE_LOAD, 10'd5, 32'h0001_0000, 1'b0, 32'h0);
    push_item(MODE_LOAD, 10'd7, 32'hFFFF_FFFF, 1'b0, 32'h0);
    push_item(MODE_NONZERO, 10'd5, 32'h0001_8000, 1'b0, 32'h0);
    push_item(MODE_NONZERO, 10'd0, 32'h0000_8000, 1'b1, 32'h0002_0000);
    push_item(MODE_EMPTY, 10'd0, 32'h0, 1'b0, 32'h7FFF_FFFF);
    push_item(MODE_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
    // Two largest products drive the accumulator to its positive limit, then an
    // empty-row beat closes the open row and the difference clips negative.
    push_item(MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b0, 32'h0);
    push_item(MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b0, 32'h0);
    push_item(MODE_EMPTY, 10'd0, 32'h0, 1'b0, 32'h8000_0000);
    push_item(MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b0, 32'h0);
    push_item(MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b0, 32'h0);
    push_item(MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b0, 32'h0);
    push_item(MODE_NONZERO, 10'd5, 32'h0, 1'b1, 32'h7FFF_FFFF);
    push_item(MODE_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // Exact halves round toward plus infinity.
    push_item(MODE_NONZERO, 10'd7, 32'hFFFF_8000, 1'b1, 32'h0);
    push_item(MODE_NONZERO, 10'd7, 32'h0000_8000, 1'b1, 32'h0);
    push_item(MODE_NONZERO, 10'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(MODE_NONZERO, 10'd0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
    drain();

    write_subtract(1'b0);
    push_item(MODE_NONZERO, 10'd0, 32'h7FFF_FFFF, 1'b1, 32'h0);
    push_item(MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b1, 32'h0);
    push_item(MODE_EMPTY, 10'd0, 32'h0, 1'b0, 32'h1234_5678);
    push_item(MODE_NONZERO, 10'd5, 32'h0001_8000, 1'b1, 32'h0);
    drain();

    write_subtract(1'b1);
    random_phase(260);
    drain();

    write_subtract(1'b0);
    random_phase(260);
    drain();

    // Receiver holds off for a long stretch while beats keep coming.
    write_subtract(1'b1);
    random_phase(260);
    hold_asked <= hold_asked + 1;
    drain();

    write_subtract(1'b0);
    random_phase(260);
    drain();

    write_subtract(1'b1);
    random_phase(260);
    drain();
    repeat (20) @(posedge clk_i);

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
